// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros used by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hdl/lpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg
// types and constants of the lru pattern cache
// ----------------------------------------------------------------------------
package lpc_pkg;

   localparam int SLOTS_DEFAULT     = 32;
   localparam int KEY_WIDTH_DEFAULT = 64;

   localparam int KEY_W    = 64;
   localparam int LEN_W    = 17;
   localparam int STATES_W = 20;
   localparam int STAMP_W  = 64;
   localparam int SLOT_W   = 5;

   localparam logic [LEN_W-1:0]    MAX_KEY_LENGTH   = LEN_W'(64 * 1024);
   localparam logic [STATES_W-1:0] MAX_STATES_RESET = STATES_W'(10000);

   typedef enum logic [2:0] {
      ST_HIT     = 3'd0,
      ST_STORED  = 3'd1,
      ST_LENGTH  = 3'd2,
      ST_COMPILE = 3'd3,
      ST_STATES  = 3'd4
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [LEN_W-1:0]    key_length;
      logic                compile_ok;
      logic [STATES_W-1:0] state_count;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
      logic               replaced_valid;
   } rsp_type;

   // low bits of a slot index, for any index up to eight bits
   function automatic logic [SLOT_W-1:0] slot_field(input logic [7:0] idx);
      return idx[SLOT_W-1:0];
   endfunction

endpackage

// ----- hdl/lpc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/lru_pattern_cache.sv -----
`timescale 1ns / 1ps
// a length error answers in the cycle after start; any other request answers
//   after the scan of all SLOTS entries and the wait and finish states
// no new request is taken until the block is back in idle (busy low); the scan
//   reads one entry per cycle from the entry ram read port
// reset clears valid bits, use clock, max_states (to 10000) and the fsm
// results are strobed for one cycle on rsp_valid, the receiver cannot stall
// ----------------------------------------------------------------------------
// lru_pattern_cache
// fully associative cache with lru replacement by use stamps, entries in ram
// ----------------------------------------------------------------------------
module lru_pattern_cache #(
   parameter int SLOTS     = lpc_pkg::SLOTS_DEFAULT,
   parameter int KEY_WIDTH = lpc_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lpc_pkg::req_type              req_item,
   output logic                          rsp_valid,
   output lpc_pkg::rsp_type              rsp_item,
   input  logic                          csr_write_en,
   input  logic [lpc_pkg::STATES_W-1:0]  csr_write_data
);

   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LEN_W   = lpc_pkg::LEN_W;
   localparam int STAMP_W = lpc_pkg::STAMP_W;
   localparam int WORD_W  = KEY_WIDTH + LEN_W + STAMP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_WAIT   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type                      state_ff, state_in;
   lpc_pkg::req_type               req_ff, req_in;
   logic [IDX_W-1:0]               addr_ff, addr_in;
   logic                           cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]               cmp_idx_ff, cmp_idx_in;
   logic [SLOTS-1:0]               valid_ff, valid_in;
   logic [STAMP_W-1:0]             use_clock_ff, use_clock_in;
   logic [lpc_pkg::STATES_W-1:0]   max_states_ff, max_states_in;
   logic                           hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]               hit_idx_ff, hit_idx_in;
   logic                           free_found_ff, free_found_in;
   logic [IDX_W-1:0]               free_idx_ff, free_idx_in;
   logic                           min_found_ff, min_found_in;
   logic [IDX_W-1:0]               min_idx_ff, min_idx_in;
   logic [STAMP_W-1:0]             min_stamp_ff, min_stamp_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   lpc_pkg::rsp_type               rsp_item_ff, rsp_item_in;

   logic                           ram_wr_en;
   logic [IDX_W-1:0]               ram_wr_addr;
   logic [WORD_W-1:0]              ram_wr_data;
   logic                           ram_rd_en;
   logic [WORD_W-1:0]              ram_rd_data;

   logic [KEY_WIDTH-1:0]           rd_key;
   logic [LEN_W-1:0]               rd_len;
   logic [STAMP_W-1:0]             rd_stamp;
   logic                           rd_entry_valid;
   logic [KEY_WIDTH-1:0]           req_key;
   logic [STAMP_W-1:0]             new_stamp;
   logic [IDX_W-1:0]               target_idx;

   // entry store: key, length and use stamp per slot
   lpc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   // read word fields and derived values
   assign rd_stamp       = ram_rd_data[STAMP_W-1:0];
   assign rd_len         = ram_rd_data[STAMP_W +: LEN_W];
   assign rd_key         = ram_rd_data[STAMP_W + LEN_W +: KEY_WIDTH];
   assign rd_entry_valid = valid_ff[cmp_idx_ff];
   assign req_key        = req_ff.key[KEY_WIDTH-1:0];
   assign new_stamp      = use_clock_ff + STAMP_W'(1);
   assign target_idx     = free_found_ff ? free_idx_ff : min_idx_ff;

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      addr_in       = addr_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      valid_in      = valid_ff;
      use_clock_in  = use_clock_ff;
      max_states_in = max_states_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      min_found_in  = min_found_ff;
      min_idx_in    = min_idx_ff;
      min_stamp_in  = min_stamp_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = rsp_item_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hit_idx_ff;
      ram_wr_data   = {req_key, req_ff.key_length, new_stamp};
      ram_rd_en     = 1'b0;

      // register write
      if (csr_write_en) begin
         max_states_in = csr_write_data;
      end

      // compare the entry read in the previous cycle
      if (cmp_valid_ff) begin
         if (rd_entry_valid && !hit_found_ff && rd_key == req_key
               && rd_len == req_ff.key_length) begin
            hit_found_in = 1'b1;
            hit_idx_in   = cmp_idx_ff;
         end
         if (!rd_entry_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
         if (rd_entry_valid && (!min_found_ff || rd_stamp < min_stamp_ff)) begin
            min_found_in = 1'b1;
            min_idx_in   = cmp_idx_ff;
            min_stamp_in = rd_stamp;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_item;
               if (req_item.key_length > lpc_pkg::MAX_KEY_LENGTH) begin
                  rsp_valid_in = 1'b1;
                  rsp_item_in  = '{status: lpc_pkg::ST_LENGTH, slot: '0,
                                   replaced_valid: 1'b0};
               end else begin
                  state_in      = S_SCAN;
                  addr_in       = '0;
                  hit_found_in  = 1'b0;
                  free_found_in = 1'b0;
                  min_found_in  = 1'b0;
               end
            end
         end
         // one entry read per cycle
         S_SCAN: begin
            ram_rd_en    = 1'b1;
            cmp_valid_in = 1'b1;
            cmp_idx_in   = addr_ff;
            if (addr_ff == LAST_IDX) begin
               state_in = S_WAIT;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         // last entry is compared here
         S_WAIT: begin
            state_in = S_FINISH;
         end
         // decide, write back and answer
         S_FINISH: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (hit_found_ff) begin
               ram_wr_en    = 1'b1;
               ram_wr_addr  = hit_idx_ff;
               use_clock_in = new_stamp;
               rsp_item_in  = '{status: lpc_pkg::ST_HIT,
                                slot: lpc_pkg::slot_field(8'(hit_idx_ff)),
                                replaced_valid: 1'b0};
            end else if (!req_ff.compile_ok) begin
               rsp_item_in = '{status: lpc_pkg::ST_COMPILE, slot: '0,
                               replaced_valid: 1'b0};
            end else if (req_ff.state_count > max_states_ff) begin
               rsp_item_in = '{status: lpc_pkg::ST_STATES, slot: '0,
                               replaced_valid: 1'b0};
            end else begin
               ram_wr_en            = 1'b1;
               ram_wr_addr          = target_idx;
               valid_in[target_idx] = 1'b1;
               use_clock_in         = new_stamp;
               rsp_item_in          = '{status: lpc_pkg::ST_STORED,
                                        slot: lpc_pkg::slot_field(8'(target_idx)),
                                        replaced_valid: !free_found_ff};
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cmp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         use_clock_ff  <= '0;
         max_states_ff <= lpc_pkg::MAX_STATES_RESET;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         min_found_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         addr_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         cmp_valid_ff  <= cmp_valid_in;
         valid_ff      <= valid_in;
         use_clock_ff  <= use_clock_in;
         max_states_ff <= max_states_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         min_found_ff  <= min_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         addr_ff       <= addr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_idx_ff   <= hit_idx_in;
      free_idx_ff  <= free_idx_in;
      min_idx_ff   <= min_idx_in;
      min_stamp_ff <= min_stamp_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- hdl/lpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_checker
// port-level checks of the lru pattern cache, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input lpc_pkg::req_type req_item,
   input logic             rsp_valid,
   input lpc_pkg::rsp_type rsp_item
);

   // an accepted transaction either answers at once or keeps the block busy
   `ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid)

   // an overlong key is refused in the next cycle
   `ASSERT_NEXT(a_length_reject, clock, reset, start && !busy && req_item.key_length > lpc_pkg::MAX_KEY_LENGTH, rsp_valid && rsp_item.status == lpc_pkg::ST_LENGTH)

   // errors carry no slot and no eviction
   `ASSERT_IMPLY(a_error_fields, clock, reset, rsp_valid && (rsp_item.status == lpc_pkg::ST_LENGTH || rsp_item.status == lpc_pkg::ST_COMPILE || rsp_item.status == lpc_pkg::ST_STATES), rsp_item.slot == '0 && !rsp_item.replaced_valid)

   // a hit never evicts
   `ASSERT_IMPLY(a_hit_no_evict, clock, reset, rsp_valid && rsp_item.status == lpc_pkg::ST_HIT, !rsp_item.replaced_valid)

endmodule

bind lru_pattern_cache lpc_checker u_lpc_checker (.*);
